// ----- design/fdd_pkg.sv -----
// Shared types and constants for the frame deduplication block.
// Depends on nothing; imported by every module of the block but fdd_ram.
`default_nettype none

package fdd_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // One job handed from the hashing front to the table back end.
  typedef struct packed {
    logic        clr;
    logic [31:0] hash;
  } fdd_job_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [7:0] unique_index;
    logic [9:0] first_frame;
    logic       is_new;
    logic       table_full;
  } fdd_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } fdd_state_e;

endpackage

`default_nettype wire

// ----- design/fdd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fdd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/fdd_queue.sv -----
// Short job queue between the hashing front and the table back end.
// Depends on fdd_pkg.
`default_nettype none

module fdd_queue import fdd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire fdd_job_t push_job_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output fdd_job_t      job_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  fdd_job_t          slot_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/fdd_front.sv -----
// Input front: folds each byte into the running FNV-1a hash and queues a
// job at each frame end or clear. Depends on fdd_pkg.
`default_nettype none

module fdd_front import fdd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output fdd_job_t        push_job_o
);

  logic [31:0] hash_q, hash_d;
  logic [31:0] mixed;
  logic [31:0] folded;
  logic        accept;

  assign stall_o = q_full_i;
  assign accept  = valid_i && !q_full_i;
  assign mixed   = hash_q ^ {24'd0, byte_value_i};
  assign folded  = mixed * FNV_PRIME;

  assign push_o          = accept && (op_i || last_byte_i);
  assign push_job_o.clr  = op_i;
  assign push_job_o.hash = folded;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      // restart the hash after a clear or a finished frame
      if (op_i || last_byte_i) begin
        hash_d = FNV_BASIS;
      end else begin
        hash_d = folded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fdd_back.sv -----
// Table back end: searches the stored hashes one by one, appends misses
// if not full, holds the result word. Depends on fdd_pkg and fdd_ram.
`default_nettype none

module fdd_back import fdd_pkg::*; #(
  parameter int MaxUnique = 256,
  parameter int MaxFrames = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  input  wire fdd_job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fdd_result_t   out_o
);

  localparam int AW = $clog2(MaxUnique);
  localparam int CW = AW + 1;
  localparam int FW = $clog2(MaxFrames);
  localparam int RW = 32 + FW;

  fdd_state_e  state_q, state_d;
  logic [31:0] hash_q, hash_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] fc_q, fc_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [FW-1:0] hit_first_q, hit_first_d;
  logic          out_valid_q, out_valid_d;
  fdd_result_t   out_q, out_d;

  logic          we;
  logic [RW-1:0] wdata;
  logic [RW-1:0] rdata;
  logic [31:0]   rd_hash;
  logic [FW-1:0] rd_first;
  logic          out_free;
  logic          last_entry;
  logic          tbl_full;
  logic [AW+7:0] idx_ext;
  logic [FW+9:0] first_ext;
  logic [AW-1:0] res_idx;
  logic [FW-1:0] res_first;

  assign rd_hash    = rdata[RW-1:FW];
  assign rd_first   = rdata[FW-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_entry = (({1'b0, idx_q} + 1'b1) == count_q);
  assign tbl_full   = (count_q == CW'(MaxUnique));
  assign wdata      = {hash_q, fc_q};
  assign idx_ext    = {8'd0, res_idx};
  assign first_ext  = {10'd0, res_first};

  fdd_ram #(
    .Width(RW),
    .Depth(MaxUnique)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i && !job_i.clr) begin
          state_d = (count_q == '0) ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if ((rd_hash == hash_q) || last_entry) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    hash_d      = hash_q;
    idx_d       = idx_q;
    count_d     = count_q;
    fc_d        = fc_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_first_d = hit_first_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    res_idx     = hit_idx_q;
    res_first   = hit_first_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          if (job_i.clr) begin
            count_d = '0;
            fc_d    = '0;
          end else begin
            hash_d = job_i.hash;
            idx_d  = '0;
            hit_d  = 1'b0;
          end
        end
      end
      ST_CMP: begin
        if (rd_hash == hash_q) begin
          hit_d       = 1'b1;
          hit_idx_d   = idx_q;
          hit_first_d = rd_first;
        end else if (!last_entry) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.is_new     = 1'b0;
          out_d.table_full = 1'b0;
          if (!hit_q) begin
            if (tbl_full) begin
              res_idx          = '0;
              res_first        = '0;
              out_d.table_full = 1'b1;
            end else begin
              // append at the fill point
              we           = 1'b1;
              res_idx      = count_q[AW-1:0];
              res_first    = fc_q;
              out_d.is_new = 1'b1;
              count_d      = count_q + 1'b1;
            end
          end
          fc_d = (fc_q == FW'(MaxFrames - 1)) ? '0 : fc_q + 1'b1;
          out_d.unique_index = idx_ext[7:0];
          out_d.first_frame  = first_ext[9:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fc_q        <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fc_q        <= fc_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q      <= hash_d;
    idx_q       <= idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_first_q <= hit_first_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- design/frame_dedup_fnv1a_table.sv -----
// Frame deduplication by FNV-1a hash: one byte word per cycle at the input,
// unless the job queue is full. A frame-end word queues a lookup; the back
// end reads and compares the stored hashes one at a time, which overlaps the
// next frame through a four-deep job queue.
// Reset (async, active low) restores the hash basis and empties the table,
// the frame counter and the queue; the table RAM itself is not cleared.
`default_nettype none

module frame_dedup_fnv1a_table import fdd_pkg::*; #(
  parameter int MAX_UNIQUE = 256,
  parameter int MAX_FRAMES = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input word channel
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  // result word channel
  output logic            valid_o,
  input  wire logic       stall_i,
  output logic [7:0]      unique_index_o,
  output logic [9:0]      first_frame_o,
  output logic            is_new_o,
  output logic            table_full_o
);

  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  fdd_job_t    push_job;
  fdd_job_t    q_job;
  fdd_result_t result;

  // Front: hash each data word, push a job at frame end or clear.
  fdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .op_i        (op_i),
    .byte_value_i(byte_value_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_job_o  (push_job)
  );

  // Queue: decouple hashing from the table search so each side stalls alone.
  fdd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .job_o     (q_job)
  );

  // Back: walk the stored hashes, append on a miss, hold the result word.
  fdd_back #(
    .MaxUnique(MAX_UNIQUE),
    .MaxFrames(MAX_FRAMES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (q_job),
    .pop_o      (q_pop),
    .out_valid_o(valid_o),
    .out_stall_i(stall_i),
    .out_o      (result)
  );

  assign unique_index_o = result.unique_index;
  assign first_frame_o  = result.first_frame;
  assign is_new_o       = result.is_new;
  assign table_full_o   = result.table_full;

`ifndef SYNTH
  // The front must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("job pushed into full queue");

  // Never pop an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // A full-table result carries no entry and is not new.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && table_full_o) |-> (!is_new_o && unique_index_o == 8'd0 &&
                                   first_frame_o == 10'd0))
    else $error("full-table result carries entry data");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for frame_dedup_fnv1a_table: drives frame bytes and clears,
// predicts every lookup result and checks it field by field.
// Depends on fdd_pkg and frame_dedup_fnv1a_table only.
`timescale 1ns / 100ps

module tb import fdd_pkg::*; ();

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int TABLE_SLOTS  = 256;
  localparam int FRAME_WRAP   = 1024;
  localparam int POOL_SIZE    = 8;
  localparam int N_DIRECTED   = 18;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // One row of the directed table; pinned rows carry a hand-read result.
  typedef struct packed {
    logic        op;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        pinned;
    fdd_result_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       valid_i      = 1'b0;
  wire logic  stall_o;
  logic       op_i         = OP_DATA;
  logic [7:0] byte_value_i = 8'h00;
  logic       last_byte_i  = 1'b0;
  wire logic  valid_o;
  logic       stall_i;
  wire logic [7:0] unique_index_o;
  wire logic [9:0] first_frame_o;
  wire logic  is_new_o;
  wire logic  table_full_o;

  frame_dedup_fnv1a_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .op_i          (op_i),
    .byte_value_i  (byte_value_i),
    .last_byte_i   (last_byte_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .unique_index_o(unique_index_o),
    .first_frame_o (first_frame_o),
    .is_new_o      (is_new_o),
    .table_full_o  (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow of the block: running hash, frame number and the table of seen hashes.
  logic [31:0] fnv_acc      = FNV_BASIS;
  int          shadow_frame = 0;
  int          seen_count   = 0;
  logic [31:0] seen_hash  [TABLE_SLOTS];
  logic [9:0]  seen_first [TABLE_SLOTS];

  fdd_result_t lookup_results_due [$];
  fdd_result_t due_word;
  int          err_count = 0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  logic [47:0] pool_data [POOL_SIZE];
  int          pool_len  [POOL_SIZE];

  stim_row_t directed_rows [N_DIRECTED] = '{
    // first frames after reset: two misses, then a hit on entry 0
    '{OP_DATA,  8'h00, 1'b1, 1'b1, '{8'd0, 10'd0, 1'b1, 1'b0}},
    '{OP_DATA,  8'hff, 1'b1, 1'b1, '{8'd1, 10'd1, 1'b1, 1'b0}},
    '{OP_DATA,  8'h00, 1'b1, 1'b1, '{8'd0, 10'd0, 1'b0, 1'b0}},
    '{OP_DATA,  8'h12, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h34, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h56, 1'b1, 1'b0, '0},
    // partial frame dropped by a clear with stray fields set
    '{OP_DATA,  8'hab, 1'b0, 1'b0, '0},
    '{OP_CLEAR, 8'hff, 1'b1, 1'b0, '0},
    // table and frame counter start again from zero
    '{OP_DATA,  8'h00, 1'b1, 1'b1, '{8'd0, 10'd0, 1'b1, 1'b0}},
    '{OP_DATA,  8'hff, 1'b1, 1'b1, '{8'd1, 10'd1, 1'b1, 1'b0}},
    '{OP_DATA,  8'h12, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h34, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h56, 1'b1, 1'b1, '{8'd2, 10'd2, 1'b1, 1'b0}},
    '{OP_DATA,  8'hff, 1'b1, 1'b1, '{8'd1, 10'd1, 1'b0, 1'b0}},
    '{OP_CLEAR, 8'h00, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h80, 1'b0, 1'b0, '0},
    '{OP_DATA,  8'h01, 1'b1, 1'b1, '{8'd0, 10'd0, 1'b1, 1'b0}},
    '{OP_DATA,  8'h7f, 1'b1, 1'b0, '0}
  };

  // Fold one accepted word into the shadow state; returns 1 with the lookup
  // result when the word closes a frame.
  function automatic bit dedup_lookup(input logic op, input logic [7:0] b,
                                      input logic last, output fdd_result_t res);
    int slot;
    int i;
    res  = '0;
    slot = -1;
    if (op == OP_CLEAR) begin
      seen_count   = 0;
      shadow_frame = 0;
      fnv_acc      = FNV_BASIS;
      return 1'b0;
    end
    fnv_acc = (fnv_acc ^ {24'd0, b}) * FNV_PRIME;
    if (!last) return 1'b0;
    for (i = 0; i < seen_count; i++)
      if (slot < 0 && seen_hash[i] == fnv_acc) slot = i;
    if (slot >= 0) begin
      res.unique_index = slot[7:0];
      res.first_frame  = seen_first[slot];
    end else if (seen_count < TABLE_SLOTS) begin
      seen_hash[seen_count]  = fnv_acc;
      seen_first[seen_count] = shadow_frame[9:0];
      res.unique_index       = seen_count[7:0];
      res.first_frame        = shadow_frame[9:0];
      res.is_new             = 1'b1;
      seen_count++;
    end else begin
      res.table_full = 1'b1;
    end
    shadow_frame = (shadow_frame + 1) % FRAME_WRAP;
    fnv_acc      = FNV_BASIS;
    return 1'b1;
  endfunction

  // Offer one word, idling at random first, and hold it until accepted.
  // Valid is only lowered while idling, so a following word never sees
  // valid dropped and raised in one step.
  task automatic put_word(input logic op, input logic [7:0] b, input logic last,
                          input bit pinned = 1'b0, input fdd_result_t pinned_res = '0);
    fdd_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    op_i         <= op;
    byte_value_i <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (stall_o);
    if (dedup_lookup(op, b, last, res))
      lookup_results_due.push_back(pinned ? pinned_res : res);
  endtask

  // Send a whole frame; byte k sits in data[8k +: 8].
  task automatic send_frame(input int len, input logic [47:0] data);
    for (int k = 0; k < len; k++)
      put_word(OP_DATA, data[8*k +: 8], k == len - 1);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // Pause the sender until every expected result has come back.
  task automatic wait_drained();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (lookup_results_due.size() != 0);
  endtask

  // Mostly repeats of a small pool of frames with random content, so hits
  // are common; the rest is fresh frames, clears and frames cut by a clear.
  task automatic run_mixed_traffic(input int n_words);
    int sent;
    int pick;
    int p;
    int len;
    sent = 0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k]  = $urandom_range(1, 6);
      pool_data[k] = {16'($urandom_range(16'hffff)), $urandom};
    end
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        p = $urandom_range(POOL_SIZE - 1);
        send_frame(pool_len[p], pool_data[p]);
        sent += pool_len[p];
      end else if (pick < 88) begin
        len = $urandom_range(1, 6);
        send_frame(len, {16'($urandom_range(16'hffff)), $urandom});
        sent += len;
      end else if (pick < 94) begin
        put_word(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          put_word(OP_DATA, 8'($urandom_range(255)), 1'b0);
        put_word(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += len + 1;
      end
    end
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    forever begin
      if (hold_reqs != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else begin
        stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
      @(posedge clk_i);
    end
  end

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (lookup_results_due.size() == 0) begin
        $error("result word with none due: unique_index %0d first_frame %0d",
               unique_index_o, first_frame_o);
        err_count++;
      end else begin
        due_word = lookup_results_due.pop_front();
        if (unique_index_o !== due_word.unique_index) begin
          $error("unique_index: expected %0d, got %0d", due_word.unique_index, unique_index_o);
          err_count++;
        end
        if (first_frame_o !== due_word.first_frame) begin
          $error("first_frame: expected %0d, got %0d", due_word.first_frame, first_frame_o);
          err_count++;
        end
        if (is_new_o !== due_word.is_new) begin
          $error("is_new: expected %0d, got %0d", due_word.is_new, is_new_o);
          err_count++;
        end
        if (table_full_o !== due_word.table_full) begin
          $error("table_full: expected %0d, got %0d", due_word.table_full, table_full_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog: give up on a hung block.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL frame_dedup_fnv1a_table");
    $finish;
  end

  initial begin
    int fresh_made;
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: extremes, hits, misses and clears.
    for (int r = 0; r < N_DIRECTED; r++)
      put_word(directed_rows[r].op, directed_rows[r].byte_value, directed_rows[r].last_byte,
               directed_rows[r].pinned, directed_rows[r].res);
    wait_drained();

    // Random traffic under each idling pattern in turn.
    set_idling(0, 0);
    run_mixed_traffic(150);
    wait_drained();
    set_idling(62, 0);
    run_mixed_traffic(150);
    wait_drained();
    set_idling(0, 62);
    run_mixed_traffic(150);
    wait_drained();
    set_idling(15, 15);
    run_mixed_traffic(150);
    wait_drained();

    // Back-pressure: the receiver holds off while short frames keep coming,
    // so the job queue fills and the input stalls.
    set_idling(0, 0);
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_frame(1, pool_data[$urandom_range(POOL_SIZE - 1)]);
    wait_drained();

    // Fill the table to the last slot, then push past it and revisit entries.
    set_idling(15, 15);
    put_word(OP_CLEAR, 8'h00, 1'b0);
    k = 0;
    while (seen_count < TABLE_SLOTS && k < 4 * TABLE_SLOTS) begin
      send_frame(2, {32'd0, k[15:0]});
      k++;
    end
    repeat (6) begin
      send_frame(2, {32'd0, k[15:0]});
      k++;
    end
    send_frame(2, {32'd0, 16'(k - 7)});
    repeat (8) send_frame(2, {32'd0, 16'($urandom_range(k - 1))});
    wait_drained();

    // Frame counter wrap: over a thousand short frames without a clear,
    // mostly repeats so the table stays short, with fresh frames sprinkled in
    // (one right at the top frame number) and later revisited.
    set_idling(0, 62);
    put_word(OP_CLEAR, 8'hff, 1'b1);
    fresh_made = 0;
    for (int f = 0; f < FRAME_WRAP + 80; f++) begin
      if (f % 97 == 96 || shadow_frame == FRAME_WRAP - 1) begin
        send_frame(2, {32'd0, 8'(fresh_made), 8'h5a});
        fresh_made++;
      end else if (fresh_made > 0 && $urandom_range(9) == 0) begin
        send_frame(2, {32'd0, 8'($urandom_range(fresh_made - 1)), 8'h5a});
      end else begin
        send_frame(1, pool_data[$urandom_range(3)]);
      end
    end

    // Let the last lookups and any trailing clear settle.
    valid_i <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("PASS frame_dedup_fnv1a_table");
    else
      $display("FAIL frame_dedup_fnv1a_table");
    $finish;
  end

endmodule

// ----- sim.f -----
design/fdd_pkg.sv
design/fdd_ram.sv
design/fdd_queue.sv
design/fdd_front.sv
design/fdd_back.sv
design/frame_dedup_fnv1a_table.sv
tb/sv/tb.sv
